// ===== src/dmacr_pkg.sv =====
// Shared types and constants of the DMA controller register block.
`timescale 1ns / 1ps
package dmacr_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_XFER  = 2'd2;

  localparam logic [7:0] PORT_STATUS   = 8'h08;
  localparam logic [7:0] PORT_REQUEST  = 8'h09;
  localparam logic [7:0] PORT_MASK_ONE = 8'h0A;
  localparam logic [7:0] PORT_MODE     = 8'h0B;
  localparam logic [7:0] PORT_BP_CLEAR = 8'h0C;
  localparam logic [7:0] PORT_MASTER   = 8'h0D;
  localparam logic [7:0] PORT_MASK_CLR = 8'h0E;
  localparam logic [7:0] PORT_MASK_ALL = 8'h0F;
  localparam logic [7:0] PORT_PAGE1    = 8'h83;
  localparam logic [7:0] PORT_PAGE2    = 8'h81;
  localparam logic [7:0] PORT_PAGE3    = 8'h82;

  localparam int MODE_AUTOINIT = 4;
  localparam int MODE_DECR     = 5;

  localparam int NCH = 4;

  typedef struct packed {
    logic        handled;
    logic [7:0]  read_data;
    logic        bus_write;
    logic [23:0] bus_address;
    logic [7:0]  bus_data;
    logic        terminal_count;
  } res_t;

endpackage

// ===== src/dma_controller_registers_core.sv =====
// Four-channel 8237-style DMA register file with per-byte transfer engine.
// Each result is registered in the output register, or in the skid register.
// Throughput: one word per cycle while in_stall is low; the output and skid
// registers let a word be accepted while a result still waits downstream.
// Reset (rst, synchronous): byte pointer, status and request cleared, all
// channels masked, every address, count, mode and page register zeroed.
`timescale 1ns / 1ps
module dma_controller_registers_core
  import dmacr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic        io_space,
  input  logic [7:0]  port,
  input  logic [7:0]  data,
  input  logic [1:0]  channel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        handled,
  output logic [7:0]  read_data,
  output logic        bus_write,
  output logic [23:0] bus_address,
  output logic [7:0]  bus_data,
  output logic        terminal_count
);

  logic        byte_pointer, byte_pointer_next;
  logic [7:0]  status_bits, status_bits_next;
  logic [3:0]  request_bits, request_bits_next;
  logic [3:0]  mask_bits, mask_bits_next;
  logic [15:0] base_addr [NCH];
  logic [15:0] base_addr_next [NCH];
  logic [15:0] current_addr [NCH];
  logic [15:0] current_addr_next [NCH];
  logic [15:0] base_count [NCH];
  logic [15:0] base_count_next [NCH];
  logic [15:0] current_count [NCH];
  logic [15:0] current_count_next [NCH];
  logic [7:0]  mode_byte [NCH];
  logic [7:0]  mode_byte_next [NCH];
  logic [7:0]  page_byte [NCH];
  logic [7:0]  page_byte_next [NCH];

  logic        in_accept;
  logic        out_take;
  logic        skid_valid;
  res_t        res;
  res_t        out_word;
  res_t        skid_word;

  logic [1:0]  idx;
  logic [15:0] cur_sel;
  logic [15:0] addr_cur;
  logic [15:0] count_dec;
  logic [7:0]  status_rd;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // one shared channel index: transfer channel, else the port's channel field
  assign idx       = (op == OP_XFER) ? channel : port[2:1];
  assign cur_sel   = port[0] ? current_count[idx] : current_addr[idx];
  assign addr_cur  = current_addr[idx];
  assign count_dec = current_count[idx] - 16'd1;
  assign status_rd = status_bits | {request_bits, 4'b0000};

  always_comb begin
    byte_pointer_next  = byte_pointer;
    status_bits_next   = status_bits;
    request_bits_next  = request_bits;
    mask_bits_next     = mask_bits;
    base_addr_next     = base_addr;
    current_addr_next  = current_addr;
    base_count_next    = base_count;
    current_count_next = current_count;
    mode_byte_next     = mode_byte;
    page_byte_next     = page_byte;
    res                = '0;
    case (op)
      OP_READ: begin
        if (io_space) begin
          if (port[7:3] == 5'd0) begin
            res.handled       = 1'b1;
            res.read_data     = byte_pointer ? cur_sel[15:8] : cur_sel[7:0];
            byte_pointer_next = ~byte_pointer;
          end else if (port == PORT_STATUS) begin
            res.handled      = 1'b1;
            res.read_data    = status_rd;
            status_bits_next = status_rd;
          end
        end
      end
      OP_WRITE: begin
        if (io_space) begin
          if (port[7:3] == 5'd0) begin
            res.handled       = 1'b1;
            byte_pointer_next = ~byte_pointer;
            if (!port[0]) begin
              if (byte_pointer) begin
                base_addr_next[idx][15:8]    = data;
                current_addr_next[idx][15:8] = data;
              end else begin
                base_addr_next[idx][7:0]    = data;
                current_addr_next[idx][7:0] = data;
              end
            end else begin
              if (byte_pointer) begin
                base_count_next[idx][15:8]    = data;
                current_count_next[idx][15:8] = data;
              end else begin
                base_count_next[idx][7:0]    = data;
                current_count_next[idx][7:0] = data;
              end
            end
          end else begin
            res.handled = 1'b1;
            case (port)
              PORT_REQUEST:  request_bits_next[data[1:0]] = data[2];
              PORT_MASK_ONE: mask_bits_next[data[1:0]] = data[2];
              PORT_MODE:     mode_byte_next[data[1:0]] = data;
              PORT_BP_CLEAR: byte_pointer_next = 1'b0;
              PORT_MASTER: begin
                byte_pointer_next = 1'b0;
                status_bits_next  = 8'h00;
                mask_bits_next    = 4'hF;
              end
              PORT_MASK_CLR: mask_bits_next = 4'h0;
              PORT_MASK_ALL: mask_bits_next = data[3:0];
              PORT_PAGE1:    page_byte_next[1] = data;
              PORT_PAGE2:    page_byte_next[2] = data;
              PORT_PAGE3:    page_byte_next[3] = data;
              default:       res.handled = 1'b0;
            endcase
          end
        end
      end
      OP_XFER: begin
        res.bus_write          = 1'b1;
        res.bus_address        = {page_byte[idx], addr_cur};
        res.bus_data           = data;
        current_addr_next[idx] = mode_byte[idx][MODE_DECR] ? addr_cur - 16'd1
                                                            : addr_cur + 16'd1;
        current_count_next[idx] = count_dec;
        if (count_dec == 16'hFFFF) begin
          res.terminal_count = 1'b1;
          if (mode_byte[idx][MODE_AUTOINIT]) begin
            current_addr_next[idx]  = base_addr[idx];
            current_count_next[idx] = base_count[idx];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pointer <= 1'b0;
      status_bits  <= 8'h00;
      request_bits <= 4'h0;
      mask_bits    <= 4'hF;
      for (int i = 0; i < NCH; i++) begin
        base_addr[i]     <= 16'h0000;
        current_addr[i]  <= 16'h0000;
        base_count[i]    <= 16'h0000;
        current_count[i] <= 16'h0000;
        mode_byte[i]     <= 8'h00;
        page_byte[i]     <= 8'h00;
      end
    end else if (in_accept) begin
      byte_pointer  <= byte_pointer_next;
      status_bits   <= status_bits_next;
      request_bits  <= request_bits_next;
      mask_bits     <= mask_bits_next;
      base_addr     <= base_addr_next;
      current_addr  <= current_addr_next;
      base_count    <= base_count_next;
      current_count <= current_count_next;
      mode_byte     <= mode_byte_next;
      page_byte     <= page_byte_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_word <= skid_word;
      end
    end else if (in_accept) begin
      if (out_valid && !out_take) begin
        skid_word <= res;
      end else begin
        out_word <= res;
      end
    end
  end

  assign handled        = out_word.handled;
  assign read_data      = out_word.read_data;
  assign bus_write      = out_word.bus_write;
  assign bus_address    = out_word.bus_address;
  assign bus_data       = out_word.bus_data;
  assign terminal_count = out_word.terminal_count;

endmodule
